[design/imh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types, constants, commands and helpers of the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int CAPACITY = 256;
    localparam int KEY_BITS = 32;
    localparam int VTX_W    = 8;
    localparam int VTX_N    = 1 << VTX_W;
    localparam int IN_KEY_W = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [KEY_BITS-1:0] t_key;

    typedef struct packed {
        t_key             key;
        logic [VTX_W-1:0] vtx;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_EXTRACT  = 2'd1;
    localparam logic [1:0] KIND_DECREASE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_INS_START,
        CMD_EXT_START,
        CMD_EX_LOAD,
        CMD_DK_MAPRD,
        CMD_DK_HEAPRD,
        CMD_DK_START,
        CMD_UP_RD,
        CMD_UP_MOVE,
        CMD_PLACE,
        CMD_DN_RDL,
        CMD_DN_L,
        CMD_DN_R,
        CMD_DN_MOVE,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic cnt_one;
        logic i_zero;
        logic map_oob;
        logic vtx_mis;
        logic par_gt;
        logic l_oob;
        logic r_oob;
        logic sel;
        logic out_free;
    } t_stat;

    // Clamp an input key into the signed KEY_BITS range.
    function automatic t_key sat_key(input logic signed [IN_KEY_W-1:0] k);
        logic signed [64:0] kx;
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        kx = 65'(k);
        hi = (65'sd1 <<< (KEY_BITS - 1)) - 65'sd1;
        lo = -hi - 65'sd1;
        if (kx > hi) begin
            kx = hi;
        end else if (kx < lo) begin
            kx = lo;
        end
        return $signed(kx[KEY_BITS-1:0]);
    endfunction

endpackage

[design/imh_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_in_if
// Operation channel: kind, vertex and key with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface imh_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [1:0]                               kind;
    logic [imh_pkg::VTX_W-1:0]                vertex;
    logic signed [imh_pkg::IN_KEY_W-1:0]      key_value;

    modport source (output valid, kind, vertex, key_value, input ready);
    modport sink   (input valid, kind, vertex, key_value, output ready);
endinterface

[design/imh_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_out_if
// Result channel: removed entry, status, root entry and count.
// ----------------------------------------------------------------------------
interface imh_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [imh_pkg::VTX_W-1:0]            out_vertex;
    logic signed [31:0]                   out_key;
    logic [1:0]                           status;
    logic [imh_pkg::VTX_W-1:0]            min_vertex;
    logic signed [31:0]                   min_key;
    logic [8:0]                           count;

    modport source (output valid, out_vertex, out_key, status, min_vertex, min_key, count,
                    input ready);
    modport sink   (input valid, out_vertex, out_key, status, min_vertex, min_key, count,
                    output ready);
endinterface

[design/imh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/imh_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_dp
// Heap datapath: slot and map RAMs, sift registers, root copy, result register.
// ----------------------------------------------------------------------------
module imh_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  imh_pkg::t_cmd                       i_cmd,
    input  logic [imh_pkg::VTX_W-1:0]           i_vertex,
    input  logic signed [imh_pkg::IN_KEY_W-1:0] i_key_value,
    input  logic                                i_out_ready,
    output imh_pkg::t_stat                      o_stat,
    output logic                                o_valid,
    output logic [imh_pkg::VTX_W-1:0]           o_out_vertex,
    output logic signed [31:0]                  o_out_key,
    output logic [1:0]                          o_status,
    output logic [imh_pkg::VTX_W-1:0]           o_min_vertex,
    output logic signed [31:0]                  o_min_key,
    output logic [8:0]                          o_count
);
    localparam int IW = imh_pkg::IDX_W;
    localparam int CW = imh_pkg::CNT_W;
    localparam int XW = imh_pkg::IDX_W + 2;

    logic [IW-1:0]               r_i;
    logic [CW-1:0]               r_cnt;
    imh_pkg::t_entry             r_elem;
    imh_pkg::t_entry             r_best;
    logic [IW-1:0]               r_best_i;
    logic                        r_sel;
    logic [imh_pkg::VTX_W-1:0]   r_v;
    imh_pkg::t_key               r_key;
    imh_pkg::t_entry             r_root;
    logic [1:0]                  r_st;
    imh_pkg::t_entry             r_rm;
    logic                        r_ovalid;
    logic [imh_pkg::VTX_W-1:0]   r_o_vtx;
    logic signed [31:0]          r_o_key;
    logic [1:0]                  r_o_st;
    logic [imh_pkg::VTX_W-1:0]   r_o_mvtx;
    logic signed [31:0]          r_o_mkey;
    logic [8:0]                  r_o_cnt;

    logic [IW-1:0]               par;
    logic [XW-1:0]               lch;
    logic [XW-1:0]               rch;
    logic [XW-1:0]               cnt_x;
    logic                        out_free;
    imh_pkg::t_key               cmp_key;

    logic                        heap_we;
    logic [IW-1:0]               heap_waddr;
    imh_pkg::t_entry             heap_wdata;
    logic [IW-1:0]               heap_raddr;
    imh_pkg::t_entry             heap_rd;
    logic                        map_we;
    logic [imh_pkg::VTX_W-1:0]   map_waddr;
    logic [IW-1:0]               map_wdata;
    logic [IW-1:0]               map_rd;

    assign par      = (r_i - IW'(1)) >> 1;
    assign lch      = ({2'b00, r_i} << 1) + XW'(1);
    assign rch      = ({2'b00, r_i} << 1) + XW'(2);
    assign cnt_x    = XW'(r_cnt);
    assign out_free = !r_ovalid || i_out_ready;
    assign cmp_key  = r_sel ? r_best.key : r_elem.key;

    imh_ram #(.WIDTH(imh_pkg::ENTRY_W), .DEPTH(imh_pkg::CAPACITY)) u_heap (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rd)
    );

    imh_ram #(.WIDTH(IW), .DEPTH(imh_pkg::VTX_N)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (r_v),
        .o_rdata (map_rd)
    );

    always_comb begin
        heap_raddr = lch[IW-1:0];
        heap_we    = 1'b0;
        heap_waddr = r_i;
        heap_wdata = r_elem;
        map_we     = 1'b0;
        map_waddr  = r_elem.vtx;
        map_wdata  = r_i;
        unique case (i_cmd)
            imh_pkg::CMD_EXT_START: heap_raddr = IW'(r_cnt - CW'(1));
            imh_pkg::CMD_DK_HEAPRD: heap_raddr = map_rd;
            imh_pkg::CMD_UP_RD:     heap_raddr = par;
            imh_pkg::CMD_DN_L:      heap_raddr = rch[IW-1:0];
            imh_pkg::CMD_UP_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = heap_rd;
                map_we     = 1'b1;
                map_waddr  = heap_rd.vtx;
            end
            imh_pkg::CMD_DN_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = r_best;
                map_we     = 1'b1;
                map_waddr  = r_best.vtx;
            end
            imh_pkg::CMD_PLACE: begin
                heap_we = 1'b1;
                map_we  = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.full     = r_cnt >= CW'(imh_pkg::CAPACITY);
        o_stat.empty    = r_cnt == '0;
        o_stat.cnt_one  = r_cnt == CW'(1);
        o_stat.i_zero   = r_i == '0;
        o_stat.map_oob  = CW'(map_rd) >= r_cnt;
        o_stat.vtx_mis  = heap_rd.vtx != r_v;
        o_stat.par_gt   = heap_rd.key > r_elem.key;
        o_stat.l_oob    = lch >= cnt_x;
        o_stat.r_oob    = rch >= cnt_x;
        o_stat.sel      = r_sel;
        o_stat.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_cmd)
                imh_pkg::CMD_LATCH: begin
                    r_v   <= i_vertex;
                    r_key <= imh_pkg::sat_key(i_key_value);
                    r_st  <= imh_pkg::ST_OK;
                    r_rm  <= '0;
                end
                imh_pkg::CMD_INS_START: begin
                    if (r_cnt >= CW'(imh_pkg::CAPACITY)) begin
                        r_st <= imh_pkg::ST_FULL;
                    end else begin
                        r_i    <= IW'(r_cnt);
                        r_elem <= '{key: r_key, vtx: r_v};
                        r_cnt  <= r_cnt + CW'(1);
                    end
                end
                imh_pkg::CMD_EXT_START: begin
                    if (r_cnt == '0) begin
                        r_st <= imh_pkg::ST_EMPTY;
                    end else begin
                        r_rm  <= r_root;
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                imh_pkg::CMD_EX_LOAD: begin
                    r_elem <= heap_rd;
                    r_i    <= '0;
                end
                imh_pkg::CMD_DK_HEAPRD: r_i <= map_rd;
                imh_pkg::CMD_DK_START:  r_elem <= '{key: r_key, vtx: r_v};
                imh_pkg::CMD_UP_MOVE:   r_i <= par;
                imh_pkg::CMD_PLACE: begin
                    if (r_i == '0) begin
                        r_root <= r_elem;
                    end
                end
                imh_pkg::CMD_DN_L: begin
                    r_sel <= heap_rd.key < r_elem.key;
                    if (heap_rd.key < r_elem.key) begin
                        r_best   <= heap_rd;
                        r_best_i <= lch[IW-1:0];
                    end
                end
                imh_pkg::CMD_DN_R: begin
                    if (heap_rd.key < cmp_key) begin
                        r_sel    <= 1'b1;
                        r_best   <= heap_rd;
                        r_best_i <= rch[IW-1:0];
                    end
                end
                imh_pkg::CMD_DN_MOVE: begin
                    if (r_i == '0) begin
                        r_root <= r_best;
                    end
                    r_i <= r_best_i;
                end
                imh_pkg::CMD_OUT: begin
                    r_ovalid <= 1'b1;
                    r_o_vtx  <= r_rm.vtx;
                    r_o_key  <= 32'(r_rm.key);
                    r_o_st   <= r_st;
                    r_o_mvtx <= (r_cnt != '0) ? r_root.vtx : '0;
                    r_o_mkey <= (r_cnt != '0) ? 32'(r_root.key) : '0;
                    r_o_cnt  <= 9'(r_cnt);
                end
                default: ;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_out_vertex = r_o_vtx;
    assign o_out_key    = r_o_key;
    assign o_status     = r_o_st;
    assign o_min_vertex = r_o_mvtx;
    assign o_min_key    = r_o_mkey;
    assign o_count      = r_o_cnt;

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(imh_pkg::CAPACITY))
        else $error("entry count above capacity");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == imh_pkg::CMD_OUT |-> out_free)
        else $error("result loaded over an untaken beat");
    a_up_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == imh_pkg::CMD_UP_MOVE |-> r_i != '0)
        else $error("sift-up move from the root");
endmodule

[design/imh_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ctrl
// Operation sequencer: issues at most one datapath command per cycle.
// ----------------------------------------------------------------------------
module imh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_kind,
    input  imh_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output imh_pkg::t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_INS, S_EXT, S_EX_LD, S_DK_RDM, S_DK_CHK, S_DK_VCHK,
        S_UP_CHK, S_UP_CMP, S_PLACE, S_DN_RDL, S_DN_L, S_DN_R, S_DN_DEC, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = imh_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = imh_pkg::CMD_LATCH;
                    priority case (i_kind)
                        imh_pkg::KIND_INSERT:   n_state = S_INS;
                        imh_pkg::KIND_EXTRACT:  n_state = S_EXT;
                        imh_pkg::KIND_DECREASE: n_state = S_DK_RDM;
                        default:                n_state = S_DONE;
                    endcase
                end
            end
            S_INS: begin
                o_cmd   = imh_pkg::CMD_INS_START;
                n_state = i_stat.full ? S_DONE : S_UP_CHK;
            end
            S_EXT: begin
                o_cmd   = imh_pkg::CMD_EXT_START;
                n_state = (i_stat.empty || i_stat.cnt_one) ? S_DONE : S_EX_LD;
            end
            S_EX_LD: begin
                o_cmd   = imh_pkg::CMD_EX_LOAD;
                n_state = S_DN_RDL;
            end
            S_DK_RDM: begin
                o_cmd   = imh_pkg::CMD_DK_MAPRD;
                n_state = S_DK_CHK;
            end
            S_DK_CHK: begin
                if (i_stat.map_oob) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd   = imh_pkg::CMD_DK_HEAPRD;
                    n_state = S_DK_VCHK;
                end
            end
            S_DK_VCHK: begin
                if (i_stat.vtx_mis) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd   = imh_pkg::CMD_DK_START;
                    n_state = S_UP_CHK;
                end
            end
            S_UP_CHK: begin
                if (i_stat.i_zero) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd   = imh_pkg::CMD_UP_RD;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.par_gt) begin
                    o_cmd   = imh_pkg::CMD_UP_MOVE;
                    n_state = S_UP_CHK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd   = imh_pkg::CMD_PLACE;
                n_state = S_DONE;
            end
            S_DN_RDL: begin
                if (i_stat.l_oob) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd   = imh_pkg::CMD_DN_RDL;
                    n_state = S_DN_L;
                end
            end
            S_DN_L: begin
                o_cmd   = imh_pkg::CMD_DN_L;
                n_state = i_stat.r_oob ? S_DN_DEC : S_DN_R;
            end
            S_DN_R: begin
                o_cmd   = imh_pkg::CMD_DN_R;
                n_state = S_DN_DEC;
            end
            S_DN_DEC: begin
                if (i_stat.sel) begin
                    o_cmd   = imh_pkg::CMD_DN_MOVE;
                    n_state = S_DN_RDL;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd   = imh_pkg::CMD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;
endmodule

[design/indexed_min_heap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap of (key, vertex) entries with a vertex position map.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one operation per beat: insert, extract minimum or
//   decrease key. o_out returns exactly one result beat per operation with
//   the removed entry, a status, the root entry and the entry count.
//   Operations run one at a time; i_in.ready is high only while the
//   sequencer is idle. Each sift level costs one slot RAM read and a
//   compare (two reads on the way down); a sift moves at most
//   log2(CAPACITY) levels.
//   A finished result sits in an output register; the next beat is taken
//   while it waits, and the sequencer holds its final step only if a
//   second result would overwrite one not yet taken.
//   Reset clears the entry count and both handshakes. Slot and map RAMs
//   are not cleared: they are written before any read that matters.
// ----------------------------------------------------------------------------
module indexed_min_heap (
    input  logic      i_clk,
    input  logic      i_rst_n,
    imh_in_if.sink    i_in,
    imh_out_if.source o_out
);
    imh_pkg::t_cmd  cmd;
    imh_pkg::t_stat stat;
    logic           in_ready;

    // Sequencer: at most one command per cycle, steered by datapath status.
    imh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_kind     (i_in.kind),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Datapath: RAMs, sift registers and the result register.
    imh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_vertex     (i_in.vertex),
        .i_key_value  (i_in.key_value),
        .i_out_ready  (o_out.ready),
        .o_stat       (stat),
        .o_valid      (o_out.valid),
        .o_out_vertex (o_out.out_vertex),
        .o_out_key    (o_out.out_key),
        .o_status     (o_out.status),
        .o_min_vertex (o_out.min_vertex),
        .o_min_key    (o_out.min_key),
        .o_count      (o_out.count)
    );

    assign i_in.ready = in_ready;
endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed min-heap: a directed table of
// operations followed by random insert/extract/decrease-key traffic, each
// result beat compared against a behavioural heap held in the bench.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG = 20000;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [7:0]         ov;
        logic signed [31:0] ok;
        logic [1:0]         st;
        logic [7:0]         mv;
        logic signed [31:0] mk;
        logic [8:0]         cnt;
    } t_res;

    // One row of the directed table; chk set means exp is typed in.
    typedef struct {
        logic [1:0]         kind;
        logic [7:0]         vtx;
        logic signed [31:0] key;
        bit                 chk;
        t_res               exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    imh_in_if  in_ch();
    imh_out_if out_ch();

    indexed_min_heap u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Bench copy of the heap state.
    logic signed [31:0] heap_key [imh_pkg::CAPACITY];
    logic [7:0]         heap_vtx [imh_pkg::CAPACITY];
    int unsigned        vtx_slot [imh_pkg::VTX_N];
    bit                 vtx_seen [imh_pkg::VTX_N];
    int unsigned        held;

    t_res        pending_q[$];
    int          errors   = 0;
    int          shown    = 0;
    int          idle_cyc = 0;
    int          snd_idle = 9;
    int          rcv_idle = 82;
    bit          hold_off = 1'b0;
    bit          stim_done = 1'b0;

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic signed [31:0] tk;
        logic [7:0]         tv;
        tk = heap_key[a]; tv = heap_vtx[a];
        heap_key[a] = heap_key[b]; heap_vtx[a] = heap_vtx[b];
        heap_key[b] = tk; heap_vtx[b] = tv;
        vtx_slot[heap_vtx[a]] = a;
        vtx_slot[heap_vtx[b]] = b;
    endfunction

    function automatic void sift_up(int unsigned i);
        int unsigned p;
        while (i != 0) begin
            p = (i - 1) / 2;
            if (!(heap_key[p] > heap_key[i])) break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void sift_down(int unsigned i);
        int unsigned l, r, m;
        forever begin
            l = 2 * i + 1; r = 2 * i + 2; m = i;
            if (l < held && heap_key[l] < heap_key[m]) m = l;
            if (r < held && heap_key[r] < heap_key[m]) m = r;
            if (m == i) break;
            swap_slots(i, m);
            i = m;
        end
    endfunction

    // Apply one operation to the bench heap and return the result beat.
    function automatic t_res heap_apply(logic [1:0] kind, logic [7:0] v,
                                        logic signed [31:0] key);
        t_res        r;
        int unsigned i;
        r = '0;
        r.st = imh_pkg::ST_OK;
        if (kind == imh_pkg::KIND_INSERT) begin
            if (held >= imh_pkg::CAPACITY) begin
                r.st = imh_pkg::ST_FULL;
            end else begin
                i = held;
                held++;
                heap_key[i] = key;
                heap_vtx[i] = v;
                vtx_slot[v] = i;
                vtx_seen[v] = 1'b1;
                sift_up(i);
            end
        end else if (kind == imh_pkg::KIND_EXTRACT) begin
            if (held == 0) begin
                r.st = imh_pkg::ST_EMPTY;
            end else begin
                r.ov = heap_vtx[0];
                r.ok = heap_key[0];
                held--;
                if (held != 0) begin
                    heap_key[0] = heap_key[held];
                    heap_vtx[0] = heap_vtx[held];
                    vtx_slot[heap_vtx[0]] = 0;
                    sift_down(0);
                end
            end
        end else if (kind == imh_pkg::KIND_DECREASE) begin
            i = vtx_slot[v];
            if (i < held && heap_vtx[i] == v) begin
                heap_key[i] = key;
                sift_up(i);
            end
        end
        r.mv  = held ? heap_vtx[0] : 8'd0;
        r.mk  = held ? heap_key[0] : 32'sd0;
        r.cnt = held[8:0];
        return r;
    endfunction

    // Drive one beat; the expectation is queued at acceptance. Valid drops
    // only while the sender idles, so back-to-back beats keep it high.
    task automatic send_op(logic [1:0] kind, logic [7:0] v, logic signed [31:0] key,
                           bit chk, t_res exp);
        t_res r;
        while ($urandom_range(99) < snd_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.vertex    <= v;
        in_ch.key_value <= key;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        r = heap_apply(kind, v, key);
        if (chk && r !== exp) begin
            errors++;
            if (shown < 10) begin
                shown++;
                $display("table row disagrees with heap: row %h heap %h", exp, r);
            end
        end
        pending_q.push_back(r);
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, plus a long hold-off when asked.
    always @(negedge i_clk) begin
        if (hold_off) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.out_vertex, out_ch.out_key, out_ch.status,
                   out_ch.min_vertex, out_ch.min_key, out_ch.count};
            if (pending_q.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result beat %h", got);
                end
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (shown < 10) begin
                        shown++;
                        $display("mismatch: exp ov=%0d ok=%0d st=%0d mv=%0d mk=%0d cnt=%0d",
                                 want.ov, want.ok, want.st, want.mv, want.mk, want.cnt);
                        $display("          got ov=%0d ok=%0d st=%0d mv=%0d mk=%0d cnt=%0d",
                                 got.ov, got.ok, got.st, got.mv, got.mk, got.cnt);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles without any beat on either side while work is outstanding, outside the hold-off.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (pending_q.size() == 0 && !in_ch.valid) || hold_off) begin
            idle_cyc <= 0;
        end else begin
            idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WATCHDOG) begin
                $display("indexed_min_heap test failed");
                $finish;
            end
        end
    end

    // Pick a vertex for decrease-key that was inserted at some point, so no
    // never-written map entry is read.
    function automatic logic [7:0] seen_vertex();
        logic [7:0] v;
        v = 8'($urandom);
        for (int n = 0; n < imh_pkg::VTX_N; n++) begin
            if (vtx_seen[v]) return v;
            v++;
        end
        return v;
    endfunction

    task automatic random_op(int fill_bias);
        logic [1:0]         kind;
        logic [7:0]         v;
        logic signed [31:0] key;
        int                 pick;
        t_res               nul;
        nul  = '0;
        pick = $urandom_range(99);
        if (pick < fill_bias) kind = imh_pkg::KIND_INSERT;
        else if (pick < 75) kind = imh_pkg::KIND_EXTRACT;
        else if (pick < 97) kind = imh_pkg::KIND_DECREASE;
        else kind = KIND_UNKNOWN;
        v = 8'($urandom);
        case ($urandom_range(3))
            0: key = $urandom;
            1: key = $signed($urandom_range(200)) - 100;
            2: key = ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
            default: key = $signed($urandom_range(2000)) - 1000;
        endcase
        if (kind == imh_pkg::KIND_DECREASE) begin
            if (!vtx_seen[v] && held == 0) begin
                kind = imh_pkg::KIND_INSERT;
            end else if (!vtx_seen[v]) begin
                v = seen_vertex();
            end
            if ($urandom_range(3) != 0 && key > -2000000000) key = key - 3;
        end
        send_op(kind, v, key, 1'b0, nul);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    t_row dir_tab[$];

    function automatic t_res mk_res(logic [7:0] ov, logic signed [31:0] ok, logic [1:0] st,
                                    logic [7:0] mv, logic signed [31:0] mk, logic [8:0] c);
        t_res r;
        r.ov = ov; r.ok = ok; r.st = st; r.mv = mv; r.mk = mk; r.cnt = c;
        return r;
    endfunction

    initial begin
        t_res nul;
        nul = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = imh_pkg::KIND_INSERT;
        in_ch.vertex = '0;
        in_ch.key_value = '0;
        out_ch.ready = 1'b0;
        held = 0;
        for (int n = 0; n < imh_pkg::VTX_N; n++) begin
            vtx_slot[n] = 0;
            vtx_seen[n] = 1'b0;
        end

        // Directed table: empty extract, extremes, ties, stale decrease, unknown kind.
        dir_tab = '{
            '{imh_pkg::KIND_EXTRACT, 8'd0, 32'sd0, 1'b1,
              mk_res(0, 0, imh_pkg::ST_EMPTY, 0, 0, 0)},
            '{imh_pkg::KIND_INSERT, 8'd255, 32'sh7fffffff, 1'b1,
              mk_res(0, 0, imh_pkg::ST_OK, 255, 32'sh7fffffff, 1)},
            '{imh_pkg::KIND_INSERT, 8'd0, 32'sh80000000, 1'b1,
              mk_res(0, 0, imh_pkg::ST_OK, 0, 32'sh80000000, 2)},
            '{imh_pkg::KIND_INSERT, 8'd7, 32'sh80000000, 1'b0, nul},
            '{imh_pkg::KIND_INSERT, 8'd9, 32'sd5, 1'b0, nul},
            '{imh_pkg::KIND_DECREASE, 8'd255, -32'sd10, 1'b0, nul},
            '{imh_pkg::KIND_DECREASE, 8'd9, 32'sd50, 1'b0, nul},
            '{KIND_UNKNOWN, 8'hAA, 32'sh55555555, 1'b0, nul},
            '{imh_pkg::KIND_INSERT, 8'd9, 32'sd1, 1'b0, nul},
            '{imh_pkg::KIND_EXTRACT, 8'd0, 32'sd0, 1'b1,
              mk_res(0, 32'sh80000000, imh_pkg::ST_OK, 7, 32'sh80000000, 4)},
            '{imh_pkg::KIND_EXTRACT, 8'd0, 32'sd0, 1'b0, nul},
            '{imh_pkg::KIND_DECREASE, 8'd0, 32'sd0, 1'b0, nul},
            '{imh_pkg::KIND_EXTRACT, 8'd0, 32'sd0, 1'b0, nul},
            '{imh_pkg::KIND_EXTRACT, 8'd0, 32'sd0, 1'b0, nul},
            '{imh_pkg::KIND_EXTRACT, 8'd0, 32'sd0, 1'b0, nul},
            '{imh_pkg::KIND_EXTRACT, 8'd0, 32'sd0, 1'b0, nul},
            '{imh_pkg::KIND_EXTRACT, 8'd0, 32'sd0, 1'b1,
              mk_res(0, 0, imh_pkg::ST_EMPTY, 0, 0, 0)}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[n]) begin
            send_op(dir_tab[n].kind, dir_tab[n].vtx, dir_tab[n].key,
                    dir_tab[n].chk, dir_tab[n].exp);
        end

        // Fill to capacity, push two dropped inserts, then shrink it with no further inserts.
        snd_idle = 0; rcv_idle = 30;
        for (int n = 0; n < imh_pkg::CAPACITY + 2; n++) random_op(100);
        for (int n = 0; n < imh_pkg::CAPACITY + 2; n++) random_op(0);

        // Long receiver hold-off while the sender keeps offering beats.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 12; n++) random_op(60);
        join

        snd_idle = 9; rcv_idle = 82;
        for (int n = 0; n < 450; n++) random_op(60);
        snd_idle = 82; rcv_idle = 9;
        for (int n = 0; n < 450; n++) random_op(45);
        snd_idle = 0; rcv_idle = 0;
        for (int n = 0; n < 420; n++) random_op(55);

        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
        drain();
        if (errors == 0 && pending_q.size() == 0) begin
            $display("indexed_min_heap test passed");
        end else begin
            $display("indexed_min_heap test failed");
        end
        $finish;
    end
endmodule
